// ===== rtl/core/mps_pkg.sv =====
`default_nettype none

package mps_pkg;

    // request codes carried in request_kind
    localparam logic [2:0] REQ_NONE  = 3'd0;
    localparam logic [2:0] REQ_ADDR  = 3'd1;
    localparam logic [2:0] REQ_VOLT  = 3'd2;
    localparam logic [2:0] REQ_AMPS  = 3'd3;
    localparam logic [2:0] REQ_WATT  = 3'd4;
    localparam logic [2:0] REQ_ENER  = 3'd5;
    localparam logic [2:0] REQ_FREQ  = 3'd6;
    localparam logic [2:0] REQ_PF    = 3'd7;

    // configuration register indexes
    localparam int unsigned CFG_INDEX_BITS = 2;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_POLL_INTERVAL = 2'd0;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_REPLY_TIMEOUT = 2'd1;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_RX_GAP        = 2'd2;

    // configuration reset values
    localparam logic [15:0] POLL_INTERVAL_RESET = 16'd1000;
    localparam logic [15:0] REPLY_TIMEOUT_RESET = 16'd500;
    localparam logic [7:0]  RX_GAP_RESET        = 8'd50;

    typedef struct packed {
        logic [3:0]  bytes_in;
        logic        frame_ok;
        logic        data_valid;
        logic [31:0] frame_value;
        logic        serial_known;
    } in_item_t;

    typedef struct packed {
        logic [2:0]  request_kind;
        logic        set_serial;
        logic        led_write;
        logic        led_on;
        logic        publish;
        logic [15:0] voltage;
        logic [15:0] amps;
        logic [15:0] watts;
        logic [31:0] watt_hours;
        logic [15:0] frequency;
        logic [15:0] pf_value;
    } out_item_t;

    typedef enum logic [7:0] {
        PH_IDLE = 8'b0000_0001,
        PH_ADDR = 8'b0000_0010,
        PH_VOLT = 8'b0000_0100,
        PH_AMPS = 8'b0000_1000,
        PH_WATT = 8'b0001_0000,
        PH_ENER = 8'b0010_0000,
        PH_FREQ = 8'b0100_0000,
        PH_PF   = 8'b1000_0000
    } phase_t;

endpackage

`default_nettype wire

// ===== rtl/core/meter_poll_sequencer.sv =====
`default_nettype none

// Polling sequencer for an electricity meter. Every input transfer is one
// millisecond tick and yields exactly one result transfer. After the
// configured poll interval of idle ticks the block issues an address request
// (serial unknown) or walks voltage, current, power, energy, frequency and power
// factor requests, taking each reply once bytes have arrived and the line has
// been quiet for more than rx_gap_ms, and giving up after reply_timeout_ms.
// Rate: one tick per clock cycle while out_stall is low. Each tick passes
// through the input register and then the result register, with the state
// update between them. Configuration writes take effect on the next
// processed tick and should only be issued while no tick is in flight.
module meter_poll_sequencer #(
    parameter int unsigned TIMER_BITS = 16
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    // tick input channel
    input  wire logic                                in_valid,
    output logic                                     in_stall,
    input  wire mps_pkg::in_item_t                   in_data,
    // result output channel
    output logic                                     out_valid,
    input  wire logic                                out_stall,
    output mps_pkg::out_item_t                       out_data,
    // configuration write port
    input  wire logic                                cfg_we,
    input  wire logic [mps_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
    input  wire logic [15:0]                         cfg_data
);
    import mps_pkg::*;

    // compare width wide enough for both the timer and 16-bit thresholds
    localparam int unsigned CMP_BITS = (TIMER_BITS > 16) ? TIMER_BITS : 16;
    localparam logic [TIMER_BITS-1:0] TIMER_MAX = {TIMER_BITS{1'b1}};

    // configuration registers
    logic [15:0] poll_interval_reg;
    logic [15:0] reply_timeout_reg;
    logic [7:0]  rx_gap_reg;

    // input register stage
    logic     s1_valid_reg;
    in_item_t s1_item_reg;

    // sequencer state
    phase_t                ph_reg, ph_next;
    logic [TIMER_BITS-1:0] elapsed_reg, elapsed_next;
    logic                  started_reg, started_next;
    logic [7:0]            quiet_reg, quiet_next;
    logic [15:0]           volt_reg, volt_next;
    logic [15:0]           amps_reg, amps_next;
    logic [15:0]           watt_reg, watt_next;
    logic [31:0]           ener_reg, ener_next;
    logic [15:0]           freq_reg, freq_next;
    logic [15:0]           pf_reg, pf_next;
    logic                  hb_reg, hb_next;

    // result register
    logic      out_valid_reg;
    out_item_t out_item_reg;
    out_item_t res;

    logic s1_advance;
    logic in_take;

    // result slot is free or draining this cycle
    assign s1_advance = s1_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall   = s1_valid_reg && !s1_advance;
    assign in_take    = in_valid && !in_stall;
    assign out_valid  = out_valid_reg;
    assign out_data   = out_item_reg;

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            poll_interval_reg <= POLL_INTERVAL_RESET;
            reply_timeout_reg <= REPLY_TIMEOUT_RESET;
            rx_gap_reg        <= RX_GAP_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_POLL_INTERVAL: poll_interval_reg <= cfg_data;
                CFG_REPLY_TIMEOUT: reply_timeout_reg <= cfg_data;
                CFG_RX_GAP:        rx_gap_reg        <= cfg_data[7:0];
                default:           ; // writes past the list are dropped
            endcase
        end
    end

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (in_take)
        begin
            s1_valid_reg <= 1'b1;
        end
        else if (s1_advance)
        begin
            s1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            s1_item_reg <= in_data;
        end
    end

    // saturate a 32-bit reading to 16 bits
    function automatic logic [15:0] sat16(input logic [31:0] v);
        sat16 = (|v[31:16]) ? 16'hFFFF : v[15:0];
    endfunction

    // tick update
    logic [TIMER_BITS-1:0] elapsed_inc;
    logic [7:0]            quiet_tick;
    logic                  started_tick;
    logic                  reply_done;
    logic                  good;
    logic [CMP_BITS-1:0]   elapsed_cmp;
    logic [CMP_BITS-1:0]   timer_max_cmp;
    logic [CMP_BITS-1:0]   timeout_cmp;
    logic [CMP_BITS-1:0]   poll_cmp;
    logic                  timeout_hit;
    logic                  poll_hit;
    logic                  change;

    always_comb
    begin
        elapsed_inc  = (elapsed_reg != TIMER_MAX) ? elapsed_reg + 1'b1 : elapsed_reg;
        if (s1_item_reg.bytes_in != 4'd0)
        begin
            started_tick = 1'b1;
            quiet_tick   = 8'd0;
        end
        else
        begin
            started_tick = started_reg;
            quiet_tick   = (quiet_reg != 8'hFF) ? quiet_reg + 8'd1 : quiet_reg;
        end

        // thresholds clamped to what the timer can reach
        elapsed_cmp   = CMP_BITS'(elapsed_inc);
        timer_max_cmp = CMP_BITS'(TIMER_MAX);
        timeout_cmp   = CMP_BITS'(reply_timeout_reg);
        poll_cmp      = CMP_BITS'(poll_interval_reg);
        if (timeout_cmp > timer_max_cmp)
        begin
            timeout_cmp = timer_max_cmp;
        end
        if (poll_cmp > timer_max_cmp)
        begin
            poll_cmp = timer_max_cmp;
        end
        timeout_hit = elapsed_cmp >= timeout_cmp;
        poll_hit    = elapsed_cmp >= poll_cmp;

        reply_done = started_tick && (quiet_tick > rx_gap_reg);
        good       = s1_item_reg.frame_ok && s1_item_reg.data_valid;

        ph_next   = ph_reg;
        change    = 1'b0;
        volt_next = volt_reg;
        amps_next = amps_reg;
        watt_next = watt_reg;
        ener_next = ener_reg;
        freq_next = freq_reg;
        pf_next   = pf_reg;
        hb_next   = hb_reg;

        res              = '0;
        res.request_kind = REQ_NONE;

        unique case (ph_reg)
            PH_IDLE:
            begin
                if (poll_hit)
                begin
                    change = 1'b1;
                    if (s1_item_reg.serial_known)
                    begin
                        res.request_kind = REQ_VOLT;
                        ph_next          = PH_VOLT;
                    end
                    else
                    begin
                        res.request_kind = REQ_ADDR;
                        ph_next          = PH_ADDR;
                    end
                end
            end
            PH_ADDR:
            begin
                if (reply_done)
                begin
                    change         = 1'b1;
                    res.set_serial = s1_item_reg.frame_ok;
                    res.led_write  = 1'b1;
                    res.led_on     = s1_item_reg.frame_ok;
                    ph_next        = PH_IDLE;
                end
                else if (timeout_hit)
                begin
                    change  = 1'b1;
                    ph_next = PH_IDLE;
                end
            end
            PH_VOLT:
            begin
                if (reply_done)
                begin
                    change = 1'b1;
                    if (good)
                    begin
                        volt_next      = sat16(s1_item_reg.frame_value);
                        res.set_serial = 1'b1;
                    end
                    res.request_kind = REQ_AMPS;
                    ph_next          = PH_AMPS;
                end
                else if (timeout_hit)
                begin
                    change  = 1'b1;
                    ph_next = PH_IDLE;
                end
            end
            PH_AMPS:
            begin
                if (reply_done)
                begin
                    change = 1'b1;
                    if (good)
                    begin
                        amps_next = sat16(s1_item_reg.frame_value);
                    end
                    res.request_kind = REQ_WATT;
                    ph_next          = PH_WATT;
                end
                else if (timeout_hit)
                begin
                    change  = 1'b1;
                    ph_next = PH_IDLE;
                end
            end
            PH_WATT:
            begin
                if (reply_done)
                begin
                    change = 1'b1;
                    if (good)
                    begin
                        watt_next = sat16(s1_item_reg.frame_value);
                    end
                    res.request_kind = REQ_ENER;
                    ph_next          = PH_ENER;
                end
                else if (timeout_hit)
                begin
                    change  = 1'b1;
                    ph_next = PH_IDLE;
                end
            end
            PH_ENER:
            begin
                if (reply_done)
                begin
                    change = 1'b1;
                    if (good)
                    begin
                        ener_next = s1_item_reg.frame_value;
                    end
                    res.request_kind = REQ_FREQ;
                    ph_next          = PH_FREQ;
                end
                else if (timeout_hit)
                begin
                    change  = 1'b1;
                    ph_next = PH_IDLE;
                end
            end
            PH_FREQ:
            begin
                if (reply_done)
                begin
                    change = 1'b1;
                    if (good)
                    begin
                        freq_next = sat16(s1_item_reg.frame_value);
                    end
                    res.request_kind = REQ_PF;
                    ph_next          = PH_PF;
                end
                else if (timeout_hit)
                begin
                    change  = 1'b1;
                    ph_next = PH_IDLE;
                end
            end
            PH_PF:
            begin
                if (reply_done)
                begin
                    change = 1'b1;
                    // heartbeat only advances on a good last reading
                    if (good)
                    begin
                        pf_next       = sat16(s1_item_reg.frame_value);
                        hb_next       = !hb_reg;
                        res.led_write = 1'b1;
                        res.led_on    = !hb_reg;
                    end
                    res.publish = 1'b1;
                    ph_next     = PH_IDLE;
                end
                else if (timeout_hit)
                begin
                    change  = 1'b1;
                    ph_next = PH_IDLE;
                end
            end
            default:
            begin
                change  = 1'b1;
                ph_next = PH_IDLE;
            end
        endcase

        elapsed_next = change ? '0 : elapsed_inc;
        // a new request throws away whatever reply was in progress
        if (res.request_kind != REQ_NONE)
        begin
            started_next = 1'b0;
            quiet_next   = 8'd0;
        end
        else
        begin
            started_next = started_tick;
            quiet_next   = quiet_tick;
        end

        res.voltage    = volt_next;
        res.amps       = amps_next;
        res.watts      = watt_next;
        res.watt_hours = ener_next;
        res.frequency  = freq_next;
        res.pf_value   = pf_next;
    end

    // state commits only when the tick moves into the result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ph_reg      <= PH_IDLE;
            elapsed_reg <= '0;
            started_reg <= 1'b0;
            quiet_reg   <= 8'd0;
            volt_reg    <= 16'd0;
            amps_reg    <= 16'd0;
            watt_reg    <= 16'd0;
            ener_reg    <= 32'd0;
            freq_reg    <= 16'd0;
            pf_reg      <= 16'd0;
            hb_reg      <= 1'b0;
        end
        else if (s1_advance)
        begin
            ph_reg      <= ph_next;
            elapsed_reg <= elapsed_next;
            started_reg <= started_next;
            quiet_reg   <= quiet_next;
            volt_reg    <= volt_next;
            amps_reg    <= amps_next;
            watt_reg    <= watt_next;
            ener_reg    <= ener_next;
            freq_reg    <= freq_next;
            pf_reg      <= pf_next;
            hb_reg      <= hb_next;
        end
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (s1_advance)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_advance)
        begin
            out_item_reg <= res;
        end
    end

    // checks
    a_publish_no_request: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_item_reg.publish |-> out_item_reg.request_kind == REQ_NONE)
        else $error("publish together with a request");

    a_led_on_needs_write: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_item_reg.led_on |-> out_item_reg.led_write)
        else $error("led level without led write");

    a_addr_enters_phase: assert property (@(posedge clk) disable iff (!rst_n)
        s1_advance && res.request_kind == REQ_ADDR |=> ph_reg == PH_ADDR)
        else $error("address request did not enter address phase");

    a_publish_to_idle: assert property (@(posedge clk) disable iff (!rst_n)
        s1_advance && res.publish |=> ph_reg == PH_IDLE && elapsed_reg == '0)
        else $error("cycle end did not return to idle");

endmodule

`default_nettype wire

// ===== test/tb_meter_poll_sequencer.sv =====
module tb_meter_poll_sequencer;

    import mps_pkg::*;

    // the watchdog outlasts the slowest transfer gap or stall and any config pause
    localparam int unsigned WATCHDOG_CYCLES = 2000;
    localparam int unsigned MAX_PRINTED = 40;
    localparam logic [15:0] TIMER_MAX = 16'hFFFF;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    logic in_valid = 1'b0;
    logic in_stall;
    in_item_t in_data = '0;
    logic out_valid;
    logic out_stall = 1'b0;
    out_item_t out_data;
    logic cfg_we = 1'b0;
    logic [CFG_INDEX_BITS-1:0] cfg_index = CFG_POLL_INTERVAL;
    logic [15:0] cfg_data = '0;

    meter_poll_sequencer i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // ticks waiting to be driven and the reports they are predicted to produce
    in_item_t tick_q[$];
    out_item_t report_q[$];

    int unsigned n_queued = 0;
    int unsigned n_accepted = 0;
    int unsigned n_checked = 0;
    int unsigned err_count = 0;
    int unsigned idle_cycles = 0;
    int unsigned hold_left = 0;
    int unsigned stall_left = 0;
    bit steady = 1'b0;
    out_item_t next_report;
    out_item_t got_report;

    // configuration as the block should see it
    logic [15:0] poll_ms = POLL_INTERVAL_RESET;
    logic [15:0] timeout_ms = REPLY_TIMEOUT_RESET;
    logic [7:0] gap_ms = RX_GAP_RESET;

    // sequencer state tracked alongside the block
    phase_t meter_phase = PH_IDLE;
    logic [15:0] phase_ms = '0;
    logic reply_seen = 1'b0;
    logic [7:0] quiet_ms = '0;
    logic [15:0] hold_volt = '0;
    logic [15:0] hold_amps = '0;
    logic [15:0] hold_watts = '0;
    logic [31:0] hold_energy = '0;
    logic [15:0] hold_freq = '0;
    logic [15:0] hold_pf = '0;
    logic beat = 1'b0;

    function automatic logic [15:0] clip16(logic [31:0] v);
        return (v > 32'h0000_FFFF) ? 16'hFFFF : v[15:0];
    endfunction

    // one millisecond tick: timers first, then the phase acts on them
    task automatic poll_tick(input in_item_t t, output out_item_t r);
        logic good;
        logic moved;
        phase_t nxt;
        good = t.frame_ok && t.data_valid;
        moved = 1'b0;
        nxt = meter_phase;
        r = '0;
        r.request_kind = REQ_NONE;
        if (phase_ms < TIMER_MAX)
            phase_ms++;
        if (t.bytes_in != 4'd0)
        begin
            reply_seen = 1'b1;
            quiet_ms = '0;
        end
        else if (quiet_ms != 8'hFF)
        begin
            quiet_ms++;
        end
        // 16-bit thresholds never exceed the 16-bit timer, so no clamp applies
        if (meter_phase != PH_IDLE)
        begin
            // a reply taken in the same tick as the timeout wins
            if (reply_seen && quiet_ms > gap_ms)
            begin
                moved = 1'b1;
                case (meter_phase)
                    PH_ADDR:
                    begin
                        r.set_serial = t.frame_ok;
                        r.led_write = 1'b1;
                        r.led_on = t.frame_ok;
                        nxt = PH_IDLE;
                    end
                    PH_VOLT:
                    begin
                        if (good)
                        begin
                            hold_volt = clip16(t.frame_value);
                            r.set_serial = 1'b1;
                        end
                        r.request_kind = REQ_AMPS;
                        nxt = PH_AMPS;
                    end
                    PH_AMPS:
                    begin
                        if (good)
                            hold_amps = clip16(t.frame_value);
                        r.request_kind = REQ_WATT;
                        nxt = PH_WATT;
                    end
                    PH_WATT:
                    begin
                        if (good)
                            hold_watts = clip16(t.frame_value);
                        r.request_kind = REQ_ENER;
                        nxt = PH_ENER;
                    end
                    PH_ENER:
                    begin
                        if (good)
                            hold_energy = t.frame_value;
                        r.request_kind = REQ_FREQ;
                        nxt = PH_FREQ;
                    end
                    PH_FREQ:
                    begin
                        if (good)
                            hold_freq = clip16(t.frame_value);
                        r.request_kind = REQ_PF;
                        nxt = PH_PF;
                    end
                    default:
                    begin
                        // end of cycle publishes even on a bad frame
                        if (good)
                        begin
                            hold_pf = clip16(t.frame_value);
                            beat = ~beat;
                            r.led_write = 1'b1;
                            r.led_on = beat;
                        end
                        r.publish = 1'b1;
                        nxt = PH_IDLE;
                    end
                endcase
            end
            else if (phase_ms >= timeout_ms)
            begin
                moved = 1'b1;
                nxt = PH_IDLE;
            end
        end
        else if (phase_ms >= poll_ms)
        begin
            moved = 1'b1;
            if (t.serial_known)
            begin
                r.request_kind = REQ_VOLT;
                nxt = PH_VOLT;
            end
            else
            begin
                r.request_kind = REQ_ADDR;
                nxt = PH_ADDR;
            end
        end
        if (moved)
        begin
            meter_phase = nxt;
            phase_ms = '0;
        end
        // a fresh request throws away anything received so far
        if (r.request_kind != REQ_NONE)
        begin
            reply_seen = 1'b0;
            quiet_ms = '0;
        end
        r.voltage = hold_volt;
        r.amps = hold_amps;
        r.watts = hold_watts;
        r.watt_hours = hold_energy;
        r.frequency = hold_freq;
        r.pf_value = hold_pf;
    endtask

    task automatic note_error(string what, logic [31:0] got, logic [31:0] want);
        if (err_count < MAX_PRINTED)
            $display("%0t: %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
        err_count++;
    endtask

    task automatic compare_report(out_item_t got, out_item_t want);
        if (got.request_kind !== want.request_kind)
            note_error("request_kind", 32'(got.request_kind), 32'(want.request_kind));
        if (got.set_serial !== want.set_serial)
            note_error("set_serial", 32'(got.set_serial), 32'(want.set_serial));
        if (got.led_write !== want.led_write)
            note_error("led_write", 32'(got.led_write), 32'(want.led_write));
        if (got.led_on !== want.led_on)
            note_error("led_on", 32'(got.led_on), 32'(want.led_on));
        if (got.publish !== want.publish)
            note_error("publish", 32'(got.publish), 32'(want.publish));
        if (got.voltage !== want.voltage)
            note_error("voltage", 32'(got.voltage), 32'(want.voltage));
        if (got.amps !== want.amps)
            note_error("amps", 32'(got.amps), 32'(want.amps));
        if (got.watts !== want.watts)
            note_error("watts", 32'(got.watts), 32'(want.watts));
        if (got.watt_hours !== want.watt_hours)
            note_error("watt_hours", got.watt_hours, want.watt_hours);
        if (got.frequency !== want.frequency)
            note_error("frequency", 32'(got.frequency), 32'(want.frequency));
        if (got.pf_value !== want.pf_value)
            note_error("pf_value", 32'(got.pf_value), 32'(want.pf_value));
    endtask

    // back to back half the time (always when steady), else a short pause, rarely a long hole
    function automatic int unsigned pause_len();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (steady || r < 50)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    // input side: present one tick per transfer, hold it while stalled
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
        end
        else
        begin
            if (in_valid && !in_stall)
            begin
                poll_tick(in_data, next_report);
                report_q.push_back(next_report);
                n_accepted++;
            end
            if (!in_valid || !in_stall)
            begin
                if (hold_left > 0)
                begin
                    hold_left--;
                    in_valid <= 1'b0;
                end
                else if (tick_q.size() > 0)
                begin
                    in_data <= tick_q.pop_front();
                    in_valid <= 1'b1;
                    hold_left = pause_len();
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // output side: check each transfer, throttle with random stalls, watch for hangs
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            out_stall <= 1'b0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                got_report = out_data;
                if (report_q.size() == 0)
                    note_error("result with nothing expected",
                               32'(got_report.request_kind), '0);
                else
                    compare_report(got_report, report_q.pop_front());
                n_checked++;
            end
            if (stall_left > 0)
            begin
                stall_left--;
                out_stall <= 1'b1;
            end
            else
            begin
                stall_left = pause_len();
                out_stall <= 1'b0;
            end
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= WATCHDOG_CYCLES)
            begin
                $display("%0t: no transfer for %0d cycles", $time, WATCHDOG_CYCLES);
                $display("[FAIL] regression broken");
                $finish;
            end
        end
    end

    function automatic in_item_t make_tick(logic [3:0] nb, logic ok, logic dv,
                                           logic [31:0] val, logic known);
        in_item_t t;
        t.bytes_in = nb;
        t.frame_ok = ok;
        t.data_valid = dv;
        t.frame_value = val;
        t.serial_known = known;
        return t;
    endfunction

    task automatic push_tick(in_item_t t);
        tick_q.push_back(t);
        n_queued++;
    endtask

    // a mix of small readings, saturation edges and full-range words
    function automatic logic [31:0] pick_value();
        case ($urandom_range(0, 9))
            0: return $urandom;
            1: return 32'h0000_FFFF + $urandom_range(0, 1);
            2: return '0;
            default: return $urandom_range(0, 65535);
        endcase
    endfunction

    // reply-shaped tick: decoder mostly happy, serial mostly known
    function automatic in_item_t reply_tick(logic [3:0] nb);
        return make_tick(nb, $urandom_range(0, 99) < 88, $urandom_range(0, 99) < 88,
                         pick_value(), $urandom_range(0, 99) < 85);
    endfunction

    // bursts of reply bytes followed by just enough quiet to close the frame,
    // with some raw noise and long silences to force timeouts
    task automatic gen_traffic(int unsigned n, int unsigned noise_pct);
        int unsigned made;
        int unsigned k;
        int unsigned i;
        made = 0;
        while (made < n)
        begin
            if ($urandom_range(0, 99) < noise_pct)
            begin
                if ($urandom_range(0, 3) == 0)
                begin
                    k = $urandom_range(1, 2 * gap_ms + 6);
                    for (i = 0; i < k && made < n; i++)
                    begin
                        push_tick(reply_tick(4'd0));
                        made++;
                    end
                end
                else
                begin
                    k = $urandom_range(1, 4);
                    for (i = 0; i < k; i++)
                    begin
                        push_tick(make_tick(4'($urandom_range(0, 15)),
                                            1'($urandom_range(0, 1)),
                                            1'($urandom_range(0, 1)), $urandom,
                                            1'($urandom_range(0, 1))));
                    end
                    made += k;
                end
            end
            else
            begin
                k = $urandom_range(1, 3);
                for (i = 0; i < k; i++)
                    push_tick(reply_tick(4'($urandom_range(1, 15))));
                made += k;
                k = gap_ms + 1 + $urandom_range(0, 1);
                for (i = 0; i < k; i++)
                    push_tick(reply_tick(4'd0));
                made += k;
            end
        end
    endtask

    task automatic write_reg(logic [CFG_INDEX_BITS-1:0] idx, logic [15:0] val);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        case (idx)
            CFG_POLL_INTERVAL: poll_ms = val;
            CFG_REPLY_TIMEOUT: timeout_ms = val;
            default: gap_ms = val[7:0];
        endcase
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    // every accepted tick has been answered, plus the pipeline depth
    task automatic settle();
        while (!(n_accepted == n_queued && n_checked == n_accepted))
            @(posedge clk);
        repeat (6) @(posedge clk);
    endtask

    task automatic run_setting(logic [15:0] poll, logic [15:0] tmo, logic [7:0] gap,
                               int unsigned n, int unsigned noise_pct, bit no_idle);
        settle();
        write_reg(CFG_POLL_INTERVAL, poll);
        write_reg(CFG_REPLY_TIMEOUT, tmo);
        write_reg(CFG_RX_GAP, {8'd0, gap});
        steady = no_idle;
        gen_traffic(n, noise_pct);
    endtask

    initial
    begin
        int unsigned i;
        out_item_t left_over;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        // reset configuration: the block just counts toward its first poll
        for (i = 0; i < 8; i++)
            push_tick(make_tick(4'd0, 1'b0, 1'b0, '0, 1'b1));

        // directed: one full cycle with every reading kind and edge case
        settle();
        write_reg(CFG_POLL_INTERVAL, 16'd1);
        write_reg(CFG_REPLY_TIMEOUT, 16'd4);
        write_reg(CFG_RX_GAP, 16'd0);
        // serial unknown, so an address request; bytes then a good address reply
        push_tick(make_tick(4'd0, 1'b0, 1'b0, '0, 1'b0));
        push_tick(make_tick(4'd15, 1'b1, 1'b1, '0, 1'b0));
        push_tick(make_tick(4'd0, 1'b1, 1'b0, '0, 1'b0));
        // voltage saturates at the 16-bit limit
        push_tick(make_tick(4'd0, 1'b0, 1'b0, '0, 1'b1));
        push_tick(make_tick(4'd1, 1'b1, 1'b1, 32'hFFFF_FFFF, 1'b1));
        push_tick(make_tick(4'd0, 1'b1, 1'b1, 32'hFFFF_FFFF, 1'b1));
        // current with data marked invalid: held value stays
        push_tick(make_tick(4'd4, 1'b1, 1'b0, 32'd123, 1'b1));
        push_tick(make_tick(4'd0, 1'b1, 1'b0, 32'd1234, 1'b1));
        // power with a rejected frame
        push_tick(make_tick(4'd2, 1'b0, 1'b1, 32'd55, 1'b1));
        push_tick(make_tick(4'd0, 1'b0, 1'b1, 32'd777, 1'b1));
        // energy keeps all 32 bits
        push_tick(make_tick(4'd3, 1'b1, 1'b1, '0, 1'b1));
        push_tick(make_tick(4'd0, 1'b1, 1'b1, 32'hFFFF_FFFF, 1'b1));
        // frequency one past the 16-bit limit
        push_tick(make_tick(4'd8, 1'b1, 1'b1, '0, 1'b1));
        push_tick(make_tick(4'd0, 1'b1, 1'b1, 32'h0001_0000, 1'b1));
        // power factor closes the cycle: publish and heartbeat
        push_tick(make_tick(4'd1, 1'b1, 1'b1, 32'd999, 1'b1));
        push_tick(make_tick(4'd0, 1'b1, 1'b1, 32'd0, 1'b1));
        // bytes while idle are dropped by the address request
        push_tick(make_tick(4'd5, 1'b1, 1'b1, '0, 1'b0));
        for (i = 0; i < 4; i++)
            push_tick(make_tick(4'd0, 1'b1, 1'b1, '0, 1'b0));
        // reply closes on the very tick the timeout expires
        push_tick(make_tick(4'd0, 1'b0, 1'b0, '0, 1'b1));
        for (i = 0; i < 3; i++)
            push_tick(make_tick(4'd6, 1'b1, 1'b1, 32'd2300, 1'b1));
        push_tick(make_tick(4'd0, 1'b1, 1'b1, 32'd2301, 1'b1));

        // random settings, extremes included
        run_setting(16'd1, 16'd1, 8'd0, 20, 30, 1'b0);
        run_setting(16'd2, 16'd20, 8'd0, 100, 10, 1'b1);
        run_setting(16'd3, 16'd30, 8'd2, 100, 10, 1'b0);
        run_setting(16'd1, 16'hFFFF, 8'd255, 40, 100, 1'b0);
        run_setting(16'hFFFF, 16'd500, 8'd50, 15, 100, 1'b0);
        run_setting(16'd5, 16'd12, 8'd1, 100, 25, 1'b0);

        settle();
        while (report_q.size() > 0)
        begin
            left_over = report_q.pop_front();
            note_error("missing result", '0, 32'(left_over.request_kind));
        end
        if (err_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
